// ===== sv/hsc_pkg.sv =====
package hsc_pkg;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 16;
  localparam int HueBoundW = 16;
  localparam int SatBoundW = 9;
  localparam int HueProdW  = 25;
  localparam int SatProdW  = 18;
  localparam int HsecW     = 11;
  localparam int HueScale  = 3840;
  localparam int Latency   = 4;

  localparam logic signed [HueBoundW-1:0] HUE_LOW_RST  = 16'sd0;
  localparam logic signed [HueBoundW-1:0] HUE_HIGH_RST = 16'sd23040;
  localparam logic [SatBoundW-1:0]        SAT_LOW_RST  = 9'd0;
  localparam logic [SatBoundW-1:0]        SAT_HIGH_RST = 9'd256;
  localparam logic [7:0]                  WHITE        = 8'hFF;

  typedef enum logic [CfgIndexW-1:0] {
    REG_HUE_LOW  = 4'd0,
    REG_HUE_HIGH = 4'd1,
    REG_SAT_LOW  = 4'd2,
    REG_SAT_HIGH = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic signed [HueBoundW-1:0] hue_low;
    logic signed [HueBoundW-1:0] hue_high;
    logic [SatBoundW-1:0]        sat_low;
    logic [SatBoundW-1:0]        sat_high;
  } bounds_t;

  typedef struct packed {
    logic       valid;
    pix_t       pix;
    logic [7:0] v;
    logic [7:0] d;
    sector_t    sel;
  } s1_t;

  typedef struct packed {
    logic             valid;
    pix_t             pix;
    logic [HsecW-1:0] hsec;
    logic             grey;
    logic [7:0]       d;
    logic [7:0]       hden;
    logic [7:0]       sden;
  } s2_t;

  typedef struct packed {
    logic                       valid;
    pix_t                       pix;
    logic signed [HueProdW-1:0] hue_lhs;
    logic signed [HueProdW-1:0] hue_lo_p;
    logic signed [HueProdW-1:0] hue_hi_p;
    logic [SatProdW-1:0]        sat_lhs;
    logic [SatProdW-1:0]        sat_lo_p;
    logic [SatProdW-1:0]        sat_hi_p;
  } s3_t;

endpackage

// ===== sv/hsv_skin_pixel_classifier.sv =====
// Skin-tone pixel classifier. Takes one RGB pixel per clock (start high while busy is low)
// and returns it on the out_ ports for one cycle, marked by out_valid:
// unchanged with out_is_skin high when its hue and saturation lie inside all four bounds,
// otherwise white with out_is_skin low. The rate is one pixel per clock through four register
// stages (min/max, hue sector, bound products, compare). There is no back-pressure: results
// must be taken as they appear. busy is high only during reset. Bound registers are written
// through the cfg_ port (always ready) and should only change while no pixel is in flight.
module hsv_skin_pixel_classifier import hsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output logic                 out_valid,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_is_skin
);

  bounds_t bounds_r;
  bounds_t bounds_nxt;
  logic    accept;
  pix_t    pix;
  s1_t     s1;
  s2_t     s2;
  s3_t     s3;

  assign busy      = !rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign pix       = '{red: in_red, green: in_green, blue: in_blue};

  always_comb begin
    bounds_nxt = bounds_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HUE_LOW:  bounds_nxt.hue_low  = $signed(cfg_data[HueBoundW-1:0]);
        REG_HUE_HIGH: bounds_nxt.hue_high = $signed(cfg_data[HueBoundW-1:0]);
        REG_SAT_LOW:  bounds_nxt.sat_low  = cfg_data[SatBoundW-1:0];
        REG_SAT_HIGH: bounds_nxt.sat_high = cfg_data[SatBoundW-1:0];
        default:      bounds_nxt = bounds_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.hue_low  <= HUE_LOW_RST;
      bounds_r.hue_high <= HUE_HIGH_RST;
      bounds_r.sat_low  <= SAT_LOW_RST;
      bounds_r.sat_high <= SAT_HIGH_RST;
    end else begin
      bounds_r <= bounds_nxt;
    end
  end

  hsc_minmax u_minmax (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .pix    (pix),
    .s1     (s1)
  );

  hsc_hue u_hue (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s2    (s2)
  );

  hsc_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .bounds (bounds_r),
    .s2     (s2),
    .s3     (s3)
  );

  hsc_cmp u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .s3          (s3),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_is_skin (out_is_skin)
  );

endmodule

// ===== sv/hsc_minmax.sv =====
module hsc_minmax import hsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  pix_t pix,
  output s1_t  s1
);

  s1_t        s1_r;
  s1_t        s1_nxt;
  logic [7:0] vmax;
  logic [7:0] vmin;

  always_comb begin
    vmax = pix.red;
    vmin = pix.red;
    if (pix.green > vmax) vmax = pix.green;
    if (pix.blue > vmax) vmax = pix.blue;
    if (pix.green < vmin) vmin = pix.green;
    if (pix.blue < vmin) vmin = pix.blue;
    s1_nxt.valid = accept;
    s1_nxt.pix   = pix;
    s1_nxt.v     = vmax;
    s1_nxt.d     = vmax - vmin;
    priority if (pix.blue == vmax) begin
      s1_nxt.sel = SEL_BLUE;
    end else if (pix.green == vmax) begin
      s1_nxt.sel = SEL_GREEN;
    end else begin
      s1_nxt.sel = SEL_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.pix <= s1_nxt.pix;
    s1_r.v   <= s1_nxt.v;
    s1_r.d   <= s1_nxt.d;
    s1_r.sel <= s1_nxt.sel;
  end

  assign s1 = s1_r;

endmodule

// ===== sv/hsc_hue.sv =====
module hsc_hue import hsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  s1_t  s1,
  output s2_t  s2
);

  s2_t                s2_r;
  s2_t                s2_nxt;
  logic signed [11:0] dx;
  logic signed [11:0] rx;
  logic signed [11:0] gx;
  logic signed [11:0] bx;
  logic signed [11:0] sec;
  logic signed [11:0] sec_wrap;

  always_comb begin
    dx = $signed({4'b0, s1.d});
    rx = $signed({4'b0, s1.pix.red});
    gx = $signed({4'b0, s1.pix.green});
    bx = $signed({4'b0, s1.pix.blue});
    unique case (s1.sel)
      SEL_BLUE:  sec = (dx <<< 2) + rx - gx;
      SEL_GREEN: sec = (dx <<< 1) + bx - rx;
      SEL_RED:   sec = gx - bx;
      default:   sec = gx - bx;
    endcase
    // negative sector wraps by six sectors (360 degrees)
    sec_wrap = sec[11] ? sec + (dx <<< 2) + (dx <<< 1) : sec;

    s2_nxt.valid = s1.valid;
    s2_nxt.pix   = s1.pix;
    s2_nxt.hsec  = sec_wrap[HsecW-1:0];
    s2_nxt.grey  = (s1.d == 8'd0);
    s2_nxt.d     = s1.d;
    s2_nxt.hden  = (s1.d == 8'd0) ? 8'd1 : s1.d;
    s2_nxt.sden  = (s1.v == 8'd0) ? 8'd1 : s1.v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.pix  <= s2_nxt.pix;
    s2_r.hsec <= s2_nxt.hsec;
    s2_r.grey <= s2_nxt.grey;
    s2_r.d    <= s2_nxt.d;
    s2_r.hden <= s2_nxt.hden;
    s2_r.sden <= s2_nxt.sden;
  end

  assign s2 = s2_r;

endmodule

// ===== sv/hsc_mult.sv =====
module hsc_mult import hsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  bounds_t bounds,
  input  s2_t     s2,
  output s3_t     s3
);

  s3_t                        s3_r;
  s3_t                        s3_nxt;
  logic [HueProdW-3:0]        hmag;
  logic signed [8:0]          hden_s;
  logic [SatProdW-1:0]        sden_x;

  always_comb begin
    hmag   = (HueProdW-2)'(s2.hsec) * (HueProdW-2)'(HueScale);
    hden_s = $signed({1'b0, s2.hden});
    sden_x = SatProdW'(s2.sden);

    s3_nxt.valid    = s2.valid;
    s3_nxt.pix      = s2.pix;
    // grey pixel: hue is -1 degree, i.e. -64 over a denominator of one
    s3_nxt.hue_lhs  = s2.grey ? -(HueProdW'(64)) : $signed({2'b0, hmag});
    s3_nxt.hue_lo_p = HueProdW'(bounds.hue_low * hden_s);
    s3_nxt.hue_hi_p = HueProdW'(bounds.hue_high * hden_s);
    s3_nxt.sat_lhs  = SatProdW'({s2.d, 8'b0});
    s3_nxt.sat_lo_p = SatProdW'(SatProdW'(bounds.sat_low) * sden_x);
    s3_nxt.sat_hi_p = SatProdW'(SatProdW'(bounds.sat_high) * sden_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r.valid <= s3_nxt.valid;
    end
    s3_r.pix      <= s3_nxt.pix;
    s3_r.hue_lhs  <= s3_nxt.hue_lhs;
    s3_r.hue_lo_p <= s3_nxt.hue_lo_p;
    s3_r.hue_hi_p <= s3_nxt.hue_hi_p;
    s3_r.sat_lhs  <= s3_nxt.sat_lhs;
    s3_r.sat_lo_p <= s3_nxt.sat_lo_p;
    s3_r.sat_hi_p <= s3_nxt.sat_hi_p;
  end

  assign s3 = s3_r;

endmodule

// ===== sv/hsc_cmp.sv =====
module hsc_cmp import hsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  s3_t        s3,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_is_skin
);

  logic       valid_r;
  logic       valid_nxt;
  pix_t       pix_r;
  pix_t       pix_nxt;
  logic       skin_r;
  logic       skin_nxt;

  always_comb begin
    skin_nxt  = (s3.hue_lhs >= s3.hue_lo_p) && (s3.hue_lhs <= s3.hue_hi_p) &&
                (s3.sat_lhs >= s3.sat_lo_p) && (s3.sat_lhs <= s3.sat_hi_p);
    valid_nxt = s3.valid;
    pix_nxt   = skin_nxt ? s3.pix : pix_t'{red: WHITE, green: WHITE, blue: WHITE};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pix_r  <= pix_nxt;
    skin_r <= skin_nxt;
  end

  assign out_valid   = valid_r;
  assign out_red     = pix_r.red;
  assign out_green   = pix_r.green;
  assign out_blue    = pix_r.blue;
  assign out_is_skin = skin_r;

endmodule

// ===== sv/hsc_checker.sv =====
module hsc_checker import hsc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_is_skin
);

  // every accepted beat produces an out_valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_valid)
    else $error("accepted pixel did not produce a result");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result without accepted pixel");

  // rejected pixels are white
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_skin) |->
      (out_red == WHITE && out_green == WHITE && out_blue == WHITE))
    else $error("non-skin result is not white");

  // busy only while in reset
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy high out of reset");

endmodule

bind hsv_skin_pixel_classifier hsc_checker u_hsc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue),
  .out_is_skin (out_is_skin)
);

// ===== bench/hsv_skin_pixel_classifier_test.sv =====
module hsv_skin_pixel_classifier_test;
  import hsc_pkg::*;

  localparam int CycleLimit = 200_000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_skin;
  } classified_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [7:0]           in_red = '0;
  logic [7:0]           in_green = '0;
  logic [7:0]           in_blue = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 out_valid;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 out_is_skin;

  pix_t        pixel_backlog[$];
  classified_t expected_pixels[$];
  int          send_idle_pct = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  logic signed [HueBoundW-1:0] hue_lo_bound = HUE_LOW_RST;
  logic signed [HueBoundW-1:0] hue_hi_bound = HUE_HIGH_RST;
  logic [SatBoundW-1:0]        sat_lo_bound = SAT_LOW_RST;
  logic [SatBoundW-1:0]        sat_hi_bound = SAT_HIGH_RST;

  hsv_skin_pixel_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_is_skin (out_is_skin)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // exact hue and saturation, compared against the bounds by cross-multiplication
  function automatic classified_t classify_pixel(input pix_t p);
    longint r = longint'(p.red);
    longint g = longint'(p.green);
    longint b = longint'(p.blue);
    longint vmax, vmin, chroma, hue_num, hue_den, sat_num, sat_den;
    classified_t res;
    vmax = r;
    vmin = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    chroma = vmax - vmin;
    if (vmax == 0) begin
      sat_num = 0;
      sat_den = 1;
    end else begin
      sat_num = chroma;
      sat_den = vmax;
    end
    if (chroma == 0) begin
      hue_num = -1;
      hue_den = 1;
    end else begin
      if (b == vmax) hue_num = 60 * (4 * chroma + r - g);
      else if (g == vmax) hue_num = 60 * (2 * chroma + b - r);
      else hue_num = 60 * (g - b);
      if (hue_num < 0) hue_num += 360 * chroma;
      hue_den = chroma;
    end
    res.is_skin = (64 * hue_num >= longint'(hue_lo_bound) * hue_den) &&
                  (64 * hue_num <= longint'(hue_hi_bound) * hue_den) &&
                  (256 * sat_num >= longint'(sat_lo_bound) * sat_den) &&
                  (256 * sat_num <= longint'(sat_hi_bound) * sat_den);
    if (res.is_skin) begin
      res.red   = p.red;
      res.green = p.green;
      res.blue  = p.blue;
    end else begin
      res.red   = WHITE;
      res.green = WHITE;
      res.blue  = WHITE;
    end
    return res;
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    logic [7:0] lvl;
    p = 24'($urandom);
    lvl = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: p = {lvl, lvl, lvl};
      4: begin
        case ($urandom_range(0, 2))
          0: p.green = p.red;
          1: p.blue = p.green;
          default: p.blue = p.red;
        endcase
      end
      5: begin
        if ($urandom_range(0, 1)) p.red = {8{p.red[0]}};
        if ($urandom_range(0, 1)) p.green = {8{p.green[0]}};
        if ($urandom_range(0, 1)) p.blue = {8{p.blue[0]}};
      end
      default: begin
        p.red   = 8'($urandom_range(96, 255));
        p.green = 8'($urandom_range(32, p.red));
        p.blue  = 8'($urandom_range(0, p.green));
      end
    endcase
    return p;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver: one pixel beat offered per cycle unless idling
  always @(negedge clk) begin
    if (rst_n && pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      start    <= 1'b1;
      in_red   <= pixel_backlog[0].red;
      in_green <= pixel_backlog[0].green;
      in_blue  <= pixel_backlog[0].blue;
    end else begin
      start    <= 1'b0;
      in_red   <= 8'($urandom);
      in_green <= 8'($urandom);
      in_blue  <= 8'($urandom);
    end
  end

  always @(posedge clk) begin : monitor
    classified_t want;
    if (!rst_n) begin
      hue_lo_bound = HUE_LOW_RST;
      hue_hi_bound = HUE_HIGH_RST;
      sat_lo_bound = SAT_LOW_RST;
      sat_hi_bound = SAT_HIGH_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HUE_LOW:  hue_lo_bound = cfg_data;
          REG_HUE_HIGH: hue_hi_bound = cfg_data;
          REG_SAT_LOW:  sat_lo_bound = cfg_data[SatBoundW-1:0];
          REG_SAT_HIGH: sat_hi_bound = cfg_data[SatBoundW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_pixels.push_back(classify_pixel({in_red, in_green, in_blue}));
        void'(pixel_backlog.pop_front());
      end
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat with no pixel pending");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red", 32'(want.red), 32'(out_red));
          check_field("out_green", 32'(want.green), 32'(out_green));
          check_field("out_blue", 32'(want.blue), 32'(out_blue));
          check_field("out_is_skin", 32'(want.is_skin), 32'(out_is_skin));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_bound(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bounds(input logic [CfgDataW-1:0] hl, input logic [CfgDataW-1:0] hh,
                            input logic [CfgDataW-1:0] sl, input logic [CfgDataW-1:0] sh);
    write_bound(REG_HUE_LOW, hl);
    write_bound(REG_HUE_HIGH, hh);
    write_bound(REG_SAT_LOW, sl);
    write_bound(REG_SAT_HIGH, sh);
  endtask

  task automatic write_unused_index();
    write_bound(CfgIndexW'($urandom_range(REG_SAT_HIGH + 1, (1 << CfgIndexW) - 1)),
                16'($urandom));
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_backlog.push_back({r, g, b});
  endtask

  task automatic add_random(input int n);
    repeat (n) pixel_backlog.push_back(random_pixel());
  endtask

  task automatic drain();
    while (pixel_backlog.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    int lo, hi, sl, sh;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bounds: every colored pixel passes, grey and black do not
    send_idle_pct = 23;
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd128, 8'd128, 8'd128);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd1);
    add_pixel(8'd1, 8'd0, 8'd0);
    add_pixel(8'd254, 8'd255, 8'd255);
    add_pixel(8'd200, 8'd120, 8'd90);
    add_random(120);
    drain();

    send_idle_pct = 70;
    set_bounds(16'sd0, 16'sd3200, 16'd59, 16'd174);
    add_random(110);
    drain();

    // widest bounds, grey included
    send_idle_pct = 0;
    set_bounds(-16'sd64, 16'sd23040, 16'd0, 16'd256);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd77, 8'd77, 8'd77);
    add_random(90);
    drain();

    // only grey passes
    send_idle_pct = 23;
    set_bounds(-16'sd64, -16'sd64, 16'd0, 16'd0);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_random(90);
    drain();

    // bounds sitting exactly on hue 60 and saturation one half
    send_idle_pct = 70;
    set_bounds(16'sd3840, 16'sd3840, 16'd128, 16'd128);
    add_pixel(8'd200, 8'd200, 8'd100);
    add_pixel(8'd100, 8'd100, 8'd50);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd200, 8'd100, 8'd100);
    add_pixel(8'd255, 8'd255, 8'd128);
    add_random(90);
    drain();

    // inverted and out-of-range bounds, nothing passes
    send_idle_pct = 0;
    set_bounds(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFE00);
    write_unused_index();
    add_random(90);
    drain();

    for (int k = 0; k < 5; k++) begin
      send_idle_pct = (k % 3 == 0) ? 23 : (k % 3 == 1) ? 70 : 0;
      write_unused_index();
      if (k % 2 == 1) begin
        set_bounds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        lo = int'($urandom_range(0, 23104)) - 64;
        hi = lo + int'($urandom_range(0, 23040 - lo));
        sl = $urandom_range(0, 256);
        sh = $urandom_range(sl, 256);
        set_bounds(16'(lo), 16'(hi), 16'(sl), 16'(sh));
      end
      add_random(90);
      drain();
    end

    repeat (Latency * 4) @(posedge clk);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
